// File: src/khtbl_pkg.sv
`timescale 1ns / 1ps

package khtbl_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_HLOOK = 2'd1,
      OP_KLOOK = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   // result status carried in rsp_tuser
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISS    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_HREAD,
      S_SCAN
   } state_type;

   // config register indexes
   localparam logic [1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [1:0] CSR_TABLE_KEY  = 2'd1;
   localparam logic [1:0] CSR_KEY_SIZE   = 2'd2;

   localparam int TABLE_SIZE_W = 7;
   localparam int TABLE_KEY_W  = 8;
   localparam int KEY_SIZE_W   = 4;
   localparam int CSR_DATA_W   = 8;

   localparam int HANDLE_IN_W  = 32;
   localparam int KEY_DATA_W   = 64;
   localparam int KEY_LEN_W    = 4;
   localparam int OBJ_SIZE_W   = 16;
   localparam int HANDLE_OUT_W = 24;
   localparam int SLOT_OUT_W   = 6;
   localparam int HANDLE_IDX_W = 16;

   // handle index compare width: 16-bit debiased index plus borrow
   localparam int CMP_W = 17;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 96;

   // group of memory strobes from the sequencer to the key store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: src/khtbl_key_store.sv
`timescale 1ns / 1ps

module khtbl_key_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int KEY_W = 64
) (
   input  logic                    clock,
   input  khtbl_pkg::mem_ctl_type  ctl,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [KEY_W-1:0]        wr_data,
   input  logic [IDX_W-1:0]        rd_addr,
   input  logic [KEY_W-1:0]        cmp_key,
   input  logic [KEY_W-1:0]        cmp_mask,
   output logic [KEY_W-1:0]        rd_data,
   output logic                    match
);

   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // shared compare unit: masked equality against the registered read word
   assign match = (((rd_data_ff ^ cmp_key) & cmp_mask) == '0);

endmodule

// File: src/keyed_handle_table_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: operation; tdata: handle, key, length, size
// rsp       out  rsp_tvalid/rsp_tready  tuser: status; tdata: handle, entry key, slot
// csr       in   csr_wr_en              csr_index, csr_wdata
//
// Steps from accept to result load: allocate, handle miss and bad op finish in the
// exec step; a handle hit adds one key store read; a key lookup compares n slots (at
// most TABLE_DEPTH), one store read and one compare a cycle.
// req_tready is high only while the sequencer is idle; a finished word may wait
// in the rsp register while the next request is taken, and a held rsp stalls it.
// Reset: synchronous; the fill count next_free marks used slots, no clearing pass.

module keyed_handle_table_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BYTES   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // req
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: operation[1:0]
   input  logic [1:0]                          req_tuser,
   // tdata: handle_in[31:0], key_data[95:32], key_length[99:96],
   //        object_size[115:100], zero pad[119:116]
   input  logic [khtbl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tuser: status[1:0]
   output logic [1:0]                          rsp_tuser,
   // tdata: handle_out[23:0], entry_key[87:24], slot_index[93:88],
   //        zero pad[95:94]
   output logic [khtbl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // csr
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [khtbl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import khtbl_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W = 8 * KEY_BYTES;

   function automatic logic [KEY_W-1:0] byte_mask(input logic [3:0] nbytes);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (4'(b) < nbytes) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   // config registers
   logic [TABLE_SIZE_W-1:0] table_size_ff;
   logic [TABLE_KEY_W-1:0]  table_key_ff;
   logic [KEY_SIZE_W-1:0]   key_size_ff;

   // sequencer state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        next_free_ff, next_free_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;

   // latched request
   op_type                  op_ff;
   logic [HANDLE_OUT_W-1:0] handle_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [KEY_LEN_W-1:0]    klen_ff;
   logic [OBJ_SIZE_W-1:0]   osize_ff;

   // result register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [HANDLE_OUT_W-1:0] rsp_handle_ff;
   logic [KEY_DATA_W-1:0]   rsp_key_ff;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff;

   // key store interface
   mem_ctl_type             mem_ctl;
   logic [IDX_W-1:0]        rd_addr;
   logic [KEY_W-1:0]        rd_data;
   logic                    match;

   // decode
   logic [KEY_SIZE_W-1:0]   ks;
   logic [CMP_W-1:0]        size_eff, nf_ext, limit, hidx;
   logic                    alloc_room, alloc_small, hlook_hit, klook_ok, scan_last;
   logic                    out_free;

   // result selected this cycle
   logic                    res_valid, res_load, res_hit;
   status_type              res_status;
   logic [IDX_W-1:0]        res_slot;
   logic [KEY_W-1:0]        res_key;
   logic [HANDLE_IDX_W-1:0] res_slot16;

   assign ks = (key_size_ff > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_size_ff;

   // used slots are exactly 0 .. next_free-1 (add-only, allocate at the hint)
   always_comb begin
      size_eff = (CMP_W'(table_size_ff) > CMP_W'(TABLE_DEPTH)) ?
                 CMP_W'(TABLE_DEPTH) : CMP_W'(table_size_ff);
      nf_ext   = CMP_W'(next_free_ff);
      limit    = (nf_ext < size_eff) ? nf_ext : size_eff;
      hidx     = {1'b0, handle_ff[HANDLE_IDX_W-1:0]} - CMP_W'(1);
   end

   assign alloc_room  = nf_ext < size_eff;
   assign alloc_small = osize_ff < OBJ_SIZE_W'(ks);
   // zero handle debiases to a huge index, so it misses here too
   assign hlook_hit   = (handle_ff[HANDLE_OUT_W-1:HANDLE_IDX_W] == table_key_ff) &&
                        (hidx < limit);
   assign klook_ok    = (klen_ff != '0) && (klen_ff <= ks) && (limit != '0);
   assign scan_last   = (CMP_W'(scan_ff) + CMP_W'(1)) >= limit;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_HLOOK && hlook_hit) begin
               state_in = S_HREAD;
            end else if (op_ff == OP_KLOOK && klook_ok) begin
               state_in = S_SCAN;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_HREAD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if ((match || scan_last) && out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mem_ctl      = '0;
      rd_addr      = '0;
      next_free_in = next_free_ff;
      scan_in      = scan_ff;
      slot_in      = slot_ff;
      res_valid    = 1'b0;
      res_hit      = 1'b0;
      res_status   = STAT_MISS;
      res_slot     = '0;
      res_key      = '0;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  res_valid = 1'b1;
                  if (alloc_small) begin
                     res_status = STAT_INVALID;
                  end else if (!alloc_room) begin
                     res_status = STAT_FULL;
                  end else begin
                     res_status    = STAT_OK;
                     res_hit       = 1'b1;
                     res_slot      = next_free_ff[IDX_W-1:0];
                     res_key       = key_ff & byte_mask(ks);
                     mem_ctl.wr_en = out_free;
                     if (out_free) begin
                        next_free_in = next_free_ff + CNT_W'(1);
                     end
                  end
               end
               OP_HLOOK: begin
                  if (hlook_hit) begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = hidx[IDX_W-1:0];
                     slot_in       = hidx[IDX_W-1:0];
                  end else begin
                     res_valid  = 1'b1;
                     res_status = STAT_MISS;
                  end
               end
               OP_KLOOK: begin
                  if (klook_ok) begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = '0;
                     scan_in       = '0;
                  end else begin
                     res_valid  = 1'b1;
                     res_status = STAT_MISS;
                  end
               end
               OP_RSVD: begin
                  res_valid  = 1'b1;
                  res_status = STAT_INVALID;
               end
               default: begin
                  res_valid  = 1'b1;
                  res_status = STAT_INVALID;
               end
            endcase
         end
         S_HREAD: begin
            res_valid  = 1'b1;
            res_status = STAT_OK;
            res_hit    = 1'b1;
            res_slot   = slot_ff;
            res_key    = rd_data;
         end
         S_SCAN: begin
            // read word stays put while the result waits
            if (match) begin
               res_valid  = 1'b1;
               res_status = STAT_OK;
               res_hit    = 1'b1;
               res_slot   = scan_ff;
               res_key    = rd_data;
            end else if (scan_last) begin
               res_valid  = 1'b1;
               res_status = STAT_MISS;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = scan_ff + IDX_W'(1);
               scan_in       = scan_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign res_load   = res_valid && out_free;
   assign res_slot16 = HANDLE_IDX_W'(res_slot);

   khtbl_key_store #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W),
      .KEY_W (KEY_W)
   ) u_key_store (
      .clock    (clock),
      .ctl      (mem_ctl),
      .wr_addr  (next_free_ff[IDX_W-1:0]),
      .wr_data  (key_ff & byte_mask(ks)),
      .rd_addr  (rd_addr),
      .cmp_key  (key_ff),
      .cmp_mask (byte_mask(klen_ff)),
      .rd_data  (rd_data),
      .match    (match)
   );

   // config writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_W'(64);
         table_key_ff  <= '0;
         key_size_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_wdata[TABLE_SIZE_W-1:0];
            CSR_TABLE_KEY:  table_key_ff  <= csr_wdata[TABLE_KEY_W-1:0];
            CSR_KEY_SIZE:   key_size_ff   <= csr_wdata[KEY_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      if (req_tvalid && req_tready) begin
         op_ff     <= op_type'(req_tuser);
         handle_ff <= req_tdata[HANDLE_OUT_W-1:0];
         key_ff    <= req_tdata[32 +: KEY_W];
         klen_ff   <= req_tdata[99:96];
         osize_ff  <= req_tdata[115:100];
      end
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_hit ? {table_key_ff, res_slot16 + HANDLE_IDX_W'(1)} : '0;
         rsp_key_ff    <= res_hit ? KEY_DATA_W'(res_key) : '0;
         rsp_slot_ff   <= res_hit ? res_slot16[SLOT_OUT_W-1:0] : '0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff, rsp_key_ff, rsp_handle_ff};

`ifndef SYNTH
   // a slot is written only from the exec step, below the built depth
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == S_EXEC) && (next_free_ff < CNT_W'(TABLE_DEPTH)))
      else $error("key store write outside allocate or past depth");

   // the fill count moves only with a store write
   a_fill_tracks_write: assert property (@(posedge clock) disable iff (reset)
      !mem_ctl.wr_en |=> $stable(next_free_ff))
      else $error("next_free changed without a slot write");

   // the scan pointer stays inside the occupied, in-size range
   a_scan_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CMP_W'(scan_ff) < limit))
      else $error("key scan beyond occupied slots");

   // a success word always carries a biased, nonzero index
   a_ok_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_OK) |-> (rsp_handle_ff[15:0] != '0))
      else $error("success word with zero handle index");
`endif

endmodule
